/* hw/rtl/lfr_pkg.sv */
package lfr_pkg;

    // frame geometry and bus constants
    localparam int unsigned MAX_DATA_BYTES_DEF = 8;
    localparam int unsigned CNT_W              = 4;
    localparam int unsigned DATA_W             = 64;
    localparam logic [7:0]  SYNC_BYTE          = 8'h55;
    localparam logic [5:0]  ID_MASK            = 6'b111111;
    localparam logic [15:0] TIMER_MAX          = 16'hFFFF;

    // configuration register reset values and indexes
    localparam logic [15:0] GAP_LIMIT_RST = 16'd1040;
    localparam logic        ENHANCED_RST  = 1'b1;
    localparam int unsigned CFG_IDX_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENHANCED  = 8'd1;

    // event kinds
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // frame status codes
    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_BAD_SYNC     = 3'd1;
    localparam logic [2:0] STATUS_DATA_TIMEOUT = 3'd2;
    localparam logic [2:0] STATUS_CSUM_TIMEOUT = 3'd3;
    localparam logic [2:0] STATUS_PARITY_ERR   = 3'd4;
    localparam logic [2:0] STATUS_CSUM_ERR     = 3'd5;

    typedef struct packed {
        logic [15:0] gap_limit;
        logic        enhanced;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        frame_id;
        logic [CNT_W-1:0]  data_len;
        logic [DATA_W-1:0] data_bytes;
        logic [7:0]        frame_checksum;
    } t_result;

    // end-around-carry add of two bytes
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

    // true when the two parity bits of a protected identifier are right
    function automatic logic pid_parity_ok(input logic [7:0] pid);
        logic p0;
        logic p1;
        p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
        p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
        return (pid[7:6] == {p1, p0});
    endfunction

endpackage

/* hw/rtl/lfr_ifs.sv */
// bus event channel
interface lfr_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink (input valid, input mode, input byte_value, output ready);
endinterface

// frame status channel
interface lfr_status_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  frame_id;
    logic [3:0]  data_len;
    logic [63:0] data_bytes;
    logic [7:0]  frame_checksum;

    modport source (output valid, output status, output frame_id, output data_len,
                    output data_bytes, output frame_checksum, input ready);
    modport sink (input valid, input status, input frame_id, input data_len,
                  input data_bytes, input frame_checksum, output ready);
endinterface

// configuration write channel
interface lfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/lfr_frame_core.sv */
module lfr_frame_core #(
    parameter int unsigned MAX_DATA_BYTES = lfr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_byte,
    input  lfr_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output lfr_pkg::t_result o_res
);

    localparam int unsigned CNT_W = lfr_pkg::CNT_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_ID,
        PH_DATA,
        PH_CSUM
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_pid, n_pid;
    logic [7:0]       r_data [MAX_DATA_BYTES];
    logic [7:0]       r_last;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_timer, n_timer;
    logic [7:0]       r_sum, n_sum;
    logic             data_wr;

    logic [15:0]      timer_inc;
    logic [7:0]       sum_last;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] emit_len;
    logic [7:0]       chk_sum;
    logic [7:0]       chk_byte;
    logic [2:0]       chk_status;
    logic [63:0]      packed_data;

    // frame validation: identifier parity first, then checksum
    function automatic logic [2:0] frame_status(input logic [7:0] pid, input logic [7:0] sum,
                                                input logic [7:0] csum, input logic enh);
        logic [7:0] s;
        s = enh ? lfr_pkg::eac_add(sum, pid) : sum;
        if (!lfr_pkg::pid_parity_ok(pid)) begin
            return lfr_pkg::STATUS_PARITY_ERR;
        end else if (csum != ~s) begin
            return lfr_pkg::STATUS_CSUM_ERR;
        end
        return lfr_pkg::STATUS_OK;
    endfunction

    assign timer_inc = (r_timer != lfr_pkg::TIMER_MAX) ? r_timer + 16'd1 : r_timer;
    assign sum_last  = lfr_pkg::eac_add(r_sum, r_last);
    assign count_inc = r_count + CNT_W'(1);

    // reported length: on silence after enough bytes the newest one is the checksum
    assign emit_len = (r_phase == PH_DATA && r_count > CNT_W'(2)) ? r_count - CNT_W'(1)
                                                                  : r_count;

    // byte of the checksum and sum it is checked against, by case
    always_comb begin
        if (r_phase == PH_CSUM) begin
            chk_sum  = sum_last;
            chk_byte = i_byte;
        end else begin
            chk_sum  = r_sum;
            chk_byte = r_last;
        end
    end

    assign chk_status = frame_status(r_pid, chk_sum, chk_byte, i_cfg.enhanced);

    // pack stored data bytes below the reported length
    always_comb begin
        packed_data = '0;
        for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            if (CNT_W'(i) < emit_len) begin
                packed_data[8*i +: 8] = r_data[i];
            end
        end
    end

    // next state and result for one event
    always_comb begin
        n_phase     = r_phase;
        n_pid       = r_pid;
        n_count     = r_count;
        n_timer     = r_timer;
        n_sum       = r_sum;
        data_wr     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (i_mode)
            lfr_pkg::MODE_BREAK: begin
                n_phase = PH_SYNC;
            end
            lfr_pkg::MODE_TICK: begin
                if (r_phase == PH_DATA || r_phase == PH_CSUM) begin
                    n_timer = timer_inc;
                    if (timer_inc > i_cfg.gap_limit) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        if (r_phase == PH_CSUM) begin
                            o_res.status = lfr_pkg::STATUS_CSUM_TIMEOUT;
                        end else if (r_count > CNT_W'(2)) begin
                            o_res.status          = chk_status;
                            o_res.frame_checksum  = chk_byte;
                        end else begin
                            o_res.status = lfr_pkg::STATUS_DATA_TIMEOUT;
                        end
                        o_res.frame_id   = r_pid[5:0] & lfr_pkg::ID_MASK;
                        o_res.data_len   = emit_len;
                        o_res.data_bytes = packed_data;
                    end
                end
            end
            lfr_pkg::MODE_BYTE: begin
                unique case (r_phase)
                    PH_SYNC: begin
                        if (i_byte == lfr_pkg::SYNC_BYTE) begin
                            n_phase = PH_ID;
                        end else if (i_byte != 8'd0) begin
                            n_phase      = PH_IDLE;
                            o_res_valid  = 1'b1;
                            o_res.status = lfr_pkg::STATUS_BAD_SYNC;
                        end
                    end
                    PH_ID: begin
                        n_pid   = i_byte;
                        n_count = '0;
                        n_sum   = '0;
                        n_timer = '0;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_count != '0) begin
                            n_sum = sum_last;
                        end
                        data_wr = 1'b1;
                        n_count = count_inc;
                        n_timer = '0;
                        if (count_inc >= CNT_W'(MAX_DATA_BYTES)) begin
                            n_phase = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        n_phase              = PH_IDLE;
                        o_res_valid          = 1'b1;
                        o_res.status         = chk_status;
                        o_res.frame_id       = r_pid[5:0] & lfr_pkg::ID_MASK;
                        o_res.data_len       = emit_len;
                        o_res.data_bytes     = packed_data;
                        o_res.frame_checksum = chk_byte;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pid   <= '0;
            r_count <= '0;
            r_timer <= '0;
            r_sum   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pid   <= n_pid;
            r_count <= n_count;
            r_timer <= n_timer;
            r_sum   <= n_sum;
        end
    end

    // data byte store, newest byte kept aside for the running sum
    always_ff @(posedge i_clk) begin
        if (i_fire && data_wr) begin
            r_last <= i_byte;
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                if (r_count == CNT_W'(i)) begin
                    r_data[i] <= i_byte;
                end
            end
        end
    end

endmodule

/* hw/rtl/lfr_out_buffer.sv */
module lfr_out_buffer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lfr_pkg::t_result i_res,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output lfr_pkg::t_result o_res
);

    logic             r_out_valid;
    logic             r_skid_valid;
    lfr_pkg::t_result r_out;
    lfr_pkg::t_result r_skid;
    logic             out_free;

    assign out_free   = !r_out_valid || i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves without reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (out_free) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

/* hw/rtl/lin_frame_receiver_unit.sv */
// LIN frame receiver. Takes one bus event per clock (received byte, break, or
// microsecond tick) and reports one status transaction per finished frame: a
// good frame, bad sync, data or checksum timeout, parity or checksum error.
// Each event is processed in the cycle it is accepted, so the rate is one
// event per clock while event ready is high; the status of the event that
// ends the frame is registered in the output register or in the one skid
// entry behind it, and event ready drops only while both hold an untaken
// status. Configuration writes (gap_limit at index 0, enhanced_checksum at
// index 1) are always ready and belong in idle periods.
module lin_frame_receiver_unit #(
    parameter int unsigned MAX_DATA_BYTES = lfr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lfr_event_if.sink    i_evt,
    lfr_cfg_if.sink      i_cfg,
    lfr_status_if.source o_status
);

    lfr_pkg::t_cfg    r_cfg;
    lfr_pkg::t_result core_res;
    lfr_pkg::t_result buf_res;
    logic             core_res_valid;
    logic             evt_fire;

    assign i_cfg.ready = 1'b1;
    assign evt_fire    = i_evt.valid && i_evt.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_limit <= lfr_pkg::GAP_LIMIT_RST;
            r_cfg.enhanced  <= lfr_pkg::ENHANCED_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lfr_pkg::CFG_GAP_LIMIT: r_cfg.gap_limit <= i_cfg.data;
                lfr_pkg::CFG_ENHANCED:  r_cfg.enhanced  <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    lfr_frame_core #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (evt_fire),
        .i_mode      (i_evt.mode),
        .i_byte      (i_evt.byte_value),
        .i_cfg       (r_cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    lfr_out_buffer u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (evt_fire && core_res_valid),
        .i_res      (core_res),
        .o_in_ready (i_evt.ready),
        .o_valid    (o_status.valid),
        .i_ready    (o_status.ready),
        .o_res      (buf_res)
    );

    assign o_status.status         = buf_res.status;
    assign o_status.frame_id       = buf_res.frame_id;
    assign o_status.data_len       = buf_res.data_len;
    assign o_status.data_bytes     = buf_res.data_bytes;
    assign o_status.frame_checksum = buf_res.frame_checksum;

    // a full skid entry implies the output register holds a status
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_evt.ready |-> o_status.valid)
        else $error("skid entry full while output register empty");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.valid |-> (o_status.status <= lfr_pkg::STATUS_CSUM_ERR))
        else $error("undefined status code");

    // bad sync carries no frame content
    a_bad_sync_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.valid && o_status.status == lfr_pkg::STATUS_BAD_SYNC) |->
        (o_status.data_len == '0 && o_status.frame_id == '0 &&
         o_status.frame_checksum == '0))
        else $error("bad sync status with frame content");

    // reported length never exceeds the data store
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.valid |-> (o_status.data_len <= lfr_pkg::CNT_W'(MAX_DATA_BYTES)))
        else $error("data length beyond store depth");

endmodule
